@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file ieb_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ieb_pkg.sv @@
// ----------------------------------------------------------------------------
// ieb_pkg
// Types, codes and constants of the incremental bit-quad Euler number block.
// ----------------------------------------------------------------------------
package ieb_pkg;

   // default geometry of the pixel map
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   // field widths
   localparam int COUNT_W     = 14;
   localparam int DELTA_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int COORD_W     = 6;
   localparam int SIZE_REG_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 14'sd8191;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = -14'sd8192;

   // request codes
   typedef enum logic {
      REQ_ADD   = 1'b0,
      REQ_CLEAR = 1'b1
   } req_code_type;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SET   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_RD_UP,
      ST_RD_MID,
      ST_RD_DN,
      ST_FINISH
   } state_type;

   // which neighbor row the map read addresses
   typedef enum logic [1:0] {
      ROW_UP,
      ROW_MID,
      ROW_DN
   } row_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        load_req;
      row_sel_type row_sel;
      logic        cap_up;
      logic        cap_mid;
      logic        sweep;
      logic        finish_add;
      logic        finish_clear;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_clear;
      logic out_of_range;
      logic sweep_last;
   } dp_status_type;

endpackage

@@ sv/ieb_ram.sv @@
// ----------------------------------------------------------------------------
// ieb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ieb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ieb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ieb_ctrl
// Sequencer: map sweep, three neighbor row reads, finish and response.
// ----------------------------------------------------------------------------
module ieb_ctrl
   import ieb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;

   // state register; reset begins with a sweep that zeroes the map
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (dp_status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = dp_status.is_clear ? ST_CLEAR : ST_RD_UP;
         end
         ST_CLEAR: begin
            if (dp_status.sweep_last) state_in = ST_IDLE;
         end
         ST_RD_UP: begin
            state_in = dp_status.out_of_range ? ST_FINISH : ST_RD_MID;
         end
         ST_RD_MID: state_in = ST_RD_DN;
         ST_RD_DN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd         = '0;
      dp_cmd.row_sel = ROW_MID;
      busy           = 1'b1;
      case (state_ff)
         ST_INIT: begin
            dp_cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            busy            = 1'b0;
            dp_cmd.load_req = start;
         end
         ST_CLEAR: begin
            dp_cmd.sweep        = 1'b1;
            dp_cmd.finish_clear = dp_status.sweep_last;
         end
         ST_RD_UP: begin
            dp_cmd.row_sel = ROW_UP;
         end
         ST_RD_MID: begin
            dp_cmd.row_sel = ROW_MID;
            dp_cmd.cap_up  = 1'b1;
         end
         ST_RD_DN: begin
            dp_cmd.row_sel = ROW_DN;
            dp_cmd.cap_mid = 1'b1;
         end
         ST_FINISH: begin
            dp_cmd.finish_add = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ sv/ieb_datapath.sv @@
// ----------------------------------------------------------------------------
// ieb_datapath
// Pixel map, size registers, neighbor capture, quad scoring and count update.
// ----------------------------------------------------------------------------
module ieb_datapath
   import ieb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request fields
   input  logic                      req_type,
   input  logic [COORD_W-1:0]        req_pixel_x,
   input  logic [COORD_W-1:0]        req_pixel_y,
   input  logic signed [COUNT_W-1:0] req_start_count,
   // register writes
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [SIZE_REG_W-1:0]     csr_wr_data,
   // controller
   input  dp_cmd_type                dp_cmd,
   output dp_status_type             dp_status,
   // response
   output logic                      rsp_valid,
   output logic signed [COUNT_W-1:0] rsp_euler_count,
   output logic signed [DELTA_W-1:0] rsp_euler_delta,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int IW  = $clog2(MAX_WIDTH);
   localparam int AW  = $clog2(MAX_HEIGHT);
   localparam int XCW = (IW > COORD_W) ? IW : COORD_W;
   localparam int SWW = ($clog2(MAX_WIDTH + 1) > SIZE_REG_W) ? $clog2(MAX_WIDTH + 1)
                                                             : SIZE_REG_W;
   localparam int SWH = ($clog2(MAX_HEIGHT + 1) > SIZE_REG_W) ? $clog2(MAX_HEIGHT + 1)
                                                              : SIZE_REG_W;
   localparam logic [SWW-1:0] MAX_W_C = SWW'(MAX_WIDTH);
   localparam logic [SWH-1:0] MAX_H_C = SWH'(MAX_HEIGHT);
   localparam logic [AW-1:0]  LAST_ROW = AW'(MAX_HEIGHT - 1);

   // the three pixels at columns x-1, x, x+1 of one row; left of column 0 is zero
   function automatic logic [2:0] pick3(input logic [MAX_WIDTH-1:0] row,
                                        input logic [IW-1:0] col);
      logic [MAX_WIDTH+1:0] padded;
      padded = {1'b0, row, 1'b0};
      return padded[col +: 3];
   endfunction

   // one quad's share of Q1 - Q3 + 2*QD
   function automatic logic signed [2:0] quad_score(input logic a, input logic b,
                                                    input logic c, input logic d);
      logic [2:0] s;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      case (s)
         3'd1:    return 3'sd1;
         3'd3:    return -3'sd1;
         3'd2:    return (a == d && b == c) ? 3'sd2 : 3'sd0;
         default: return 3'sd0;
      endcase
   endfunction

   // registers
   logic [SIZE_REG_W-1:0]     width_ff, width_in;
   logic [SIZE_REG_W-1:0]     height_ff, height_in;
   logic [COORD_W-1:0]        x_ff, x_in;
   logic [COORD_W-1:0]        y_ff, y_in;
   logic signed [COUNT_W-1:0] start_count_ff, start_count_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]             sweep_cnt_ff, sweep_cnt_in;
   logic [2:0]                up_bits_ff, up_bits_in;
   logic [2:0]                mid_bits_ff, mid_bits_in;
   logic [MAX_WIDTH-1:0]      mid_row_ff, mid_row_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic signed [DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   // geometry
   logic [SWW-1:0]       active_w, x_ext, x_p1;
   logic [SWH-1:0]       active_h, y_ext, y_m1, y_p1;
   logic [XCW-1:0]       x_cext;
   logic [IW-1:0]        col_idx;
   logic [AW-1:0]        y_addr, up_addr, dn_addr;
   logic                 out_of_range, up_ok, dn_ok, right_ok;

   // map access
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [MAX_WIDTH-1:0] ram_wr_data, ram_rd_data;
   logic [2:0]           rd_bits, dn_bits;
   logic                 mid_set;

   // scoring
   logic [2:0][2:0]           n_before, n_after;
   logic signed [4:0]         sum_c;
   logic signed [DELTA_W-1:0] delta_c;
   logic signed [COUNT_W:0]   count_sum;
   logic signed [COUNT_W-1:0] count_sat;

   // active image and neighbor validity
   always_comb begin
      active_w = (SWW'(width_ff) > MAX_W_C) ? MAX_W_C : SWW'(width_ff);
      active_h = (SWH'(height_ff) > MAX_H_C) ? MAX_H_C : SWH'(height_ff);
      x_ext    = SWW'(x_ff);
      x_p1     = x_ext + SWW'(1);
      y_ext    = SWH'(y_ff);
      y_m1     = y_ext - SWH'(1);
      y_p1     = y_ext + SWH'(1);
      x_cext   = XCW'(x_ff);
      col_idx  = x_cext[IW-1:0];
      y_addr   = y_ext[AW-1:0];
      up_addr  = y_m1[AW-1:0];
      dn_addr  = y_p1[AW-1:0];
      out_of_range = (x_ext >= active_w) || (y_ext >= active_h);
      up_ok    = (y_ff != '0);
      dn_ok    = (y_p1 < active_h);
      right_ok = (x_p1 < active_w);
   end

   // map read address; neighbors off the image re-read the pixel row
   always_comb begin
      case (dp_cmd.row_sel)
         ROW_UP:  ram_rd_addr = up_ok ? up_addr : y_addr;
         ROW_MID: ram_rd_addr = y_addr;
         ROW_DN:  ram_rd_addr = dn_ok ? dn_addr : y_addr;
         default: ram_rd_addr = y_addr;
      endcase
      if (out_of_range) ram_rd_addr = '0;
   end

   // neighbor bits of the row on the read port
   always_comb begin
      rd_bits = pick3(ram_rd_data, col_idx) & {right_ok, 2'b11};
      dn_bits = rd_bits & {3{dn_ok}};
      mid_set = mid_bits_ff[1];
   end

   // quad scores before and after the pixel is set
   always_comb begin
      n_before[0] = up_bits_ff;
      n_before[1] = {mid_bits_ff[2], 1'b0, mid_bits_ff[0]};
      n_before[2] = dn_bits;
      n_after     = n_before;
      n_after[1][1] = 1'b1;
      sum_c = '0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            sum_c = sum_c
                  + 5'(quad_score(n_after[i][j], n_after[i][j+1],
                                  n_after[i+1][j], n_after[i+1][j+1]))
                  - 5'(quad_score(n_before[i][j], n_before[i][j+1],
                                  n_before[i+1][j], n_before[i+1][j+1]));
         end
      end
      // the quad sum is always a multiple of four
      delta_c   = {sum_c[4], sum_c[4:2]};
      count_sum = (COUNT_W+1)'(count_ff) + (COUNT_W+1)'(delta_c);
      if (count_sum > (COUNT_W+1)'(COUNT_MAX)) begin
         count_sat = COUNT_MAX;
      end else if (count_sum < (COUNT_W+1)'(COUNT_MIN)) begin
         count_sat = COUNT_MIN;
      end else begin
         count_sat = COUNT_W'(count_sum);
      end
   end

   // map write: sweep zeroes rows, an accepted add writes back its row
   always_comb begin
      ram_wr_en   = dp_cmd.sweep ||
                    (dp_cmd.finish_add && !out_of_range && !mid_set);
      ram_wr_addr = dp_cmd.sweep ? sweep_cnt_ff : y_addr;
      ram_wr_data = dp_cmd.sweep ? '0
                                 : (mid_row_ff | (MAX_WIDTH'(1) << col_idx));
   end

   // next register values
   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      start_count_in = start_count_ff;
      count_in       = count_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      up_bits_in     = up_bits_ff;
      mid_bits_in    = mid_bits_ff;
      mid_row_in     = mid_row_ff;
      rsp_valid_in   = 1'b0;
      rsp_count_in   = rsp_count_ff;
      rsp_delta_in   = rsp_delta_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_wr_data;
            default:          width_in  = width_ff;
         endcase
      end

      if (dp_cmd.load_req) begin
         x_in           = req_pixel_x;
         y_in           = req_pixel_y;
         start_count_in = req_start_count;
      end

      if (dp_cmd.sweep) begin
         sweep_cnt_in = (sweep_cnt_ff == LAST_ROW) ? '0 : sweep_cnt_ff + AW'(1);
      end

      if (dp_cmd.cap_up) begin
         up_bits_in = rd_bits & {3{up_ok}};
      end
      if (dp_cmd.cap_mid) begin
         mid_bits_in = rd_bits;
         mid_row_in  = ram_rd_data;
      end

      // clear transaction completes at the end of the sweep
      if (dp_cmd.finish_clear) begin
         count_in      = start_count_ff;
         rsp_valid_in  = 1'b1;
         rsp_count_in  = start_count_ff;
         rsp_delta_in  = '0;
         rsp_status_in = STATUS_DONE;
      end

      // add transaction
      if (dp_cmd.finish_add) begin
         rsp_valid_in = 1'b1;
         rsp_delta_in = '0;
         rsp_count_in = count_ff;
         if (out_of_range) begin
            rsp_status_in = STATUS_RANGE;
         end else if (mid_set) begin
            rsp_status_in = STATUS_SET;
         end else begin
            rsp_status_in = STATUS_DONE;
            rsp_delta_in  = delta_c;
            rsp_count_in  = count_sat;
            count_in      = count_sat;
         end
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         count_ff     <= '0;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      start_count_ff <= start_count_in;
      up_bits_ff     <= up_bits_in;
      mid_bits_ff    <= mid_bits_in;
      mid_row_ff     <= mid_row_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_delta_ff   <= rsp_delta_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // pixel map, one row per entry
   ieb_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign dp_status.is_clear     = (req_type == REQ_CLEAR);
   assign dp_status.out_of_range = out_of_range;
   assign dp_status.sweep_last   = (sweep_cnt_ff == LAST_ROW);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_euler_count = rsp_count_ff;
   assign rsp_euler_delta = rsp_delta_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ sv/incremental_euler_number_bitquad.sv @@
// ----------------------------------------------------------------------------
// incremental_euler_number_bitquad
// Running Euler number of a binary pixel map, updated per added pixel from
// the 2x2 bit-quads around it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on the rsp_ ports for one cycle with rsp_valid high and must
// be captured then, as the receiver cannot stall the block. An add keeps busy
// high until its response, so no new request is taken meanwhile. The pixel
// map is a RAM with one registered read port, so the rows above, at and below
// the pixel are read one after another in ST_RD_UP, ST_RD_MID and ST_RD_DN,
// and the score, count update and row write-back share ST_FINISH. An add that
// is out of range goes from ST_RD_UP straight to ST_FINISH. A clear zeroes the
// map one row per cycle in ST_CLEAR; after reset the block stays busy while the
// same sweep zeroes the map. Register writes are taken throughout.
// ----------------------------------------------------------------------------
module incremental_euler_number_bitquad
   import ieb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [COORD_W-1:0]        req_pixel_x,
   input  logic [COORD_W-1:0]        req_pixel_y,
   input  logic signed [COUNT_W-1:0] req_start_count,
   // response
   output logic                      rsp_valid,
   output logic signed [COUNT_W-1:0] rsp_euler_count,
   output logic signed [DELTA_W-1:0] rsp_euler_delta,
   output logic [STATUS_W-1:0]       rsp_status,
   // register port
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [SIZE_REG_W-1:0]     csr_wr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer
   ieb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // map and arithmetic
   ieb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_start_count (req_start_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_valid       (rsp_valid),
      .rsp_euler_count (rsp_euler_count),
      .rsp_euler_delta (rsp_euler_delta),
      .rsp_status      (rsp_status)
   );

endmodule

@@ sv/ieb_checker.sv @@
// ----------------------------------------------------------------------------
// ieb_checker
// Port-level checks of request/response sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ieb_checker
   import ieb_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic signed [DELTA_W-1:0] rsp_euler_delta,
   input logic [STATUS_W-1:0]       rsp_status
);

   // an accepted transaction makes the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // a response is shown only when the block is ready again
   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")

   // one strobe per transaction
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response repeated")

   // an ignored add reports no change
   `ASSERT_IMPLY(a_ignored_delta, clock, reset, rsp_valid && rsp_status != STATUS_DONE, rsp_euler_delta == '0, "nonzero delta on ignored add")

   // status is one of the defined codes
   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_DONE || rsp_status == STATUS_SET || rsp_status == STATUS_RANGE, "undefined status")

endmodule

bind incremental_euler_number_bitquad ieb_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_euler_delta (rsp_euler_delta),
   .rsp_status      (rsp_status)
);
